/* hdl/cds_pkg.sv */
// ----------------------------------------------------------------------------
// cds_pkg
// Types, codes and calendar helpers shared by the date stepper modules.
// ----------------------------------------------------------------------------
package cds_pkg;

  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;

  // event codes
  localparam logic [1:0] OP_RIGHT  = 2'd0;
  localparam logic [1:0] OP_LEFT   = 2'd1;
  localparam logic [1:0] OP_CENTER = 2'd2;
  localparam logic [1:0] OP_SET    = 2'd3;

  // field cursor codes
  localparam logic [1:0] MODE_NAV   = 2'd0;
  localparam logic [1:0] MODE_YEAR  = 2'd1;
  localparam logic [1:0] MODE_MONTH = 2'd2;
  localparam logic [1:0] MODE_DAY   = 2'd3;

  // page step codes
  localparam logic [1:0] PAGE_NONE = 2'd0;
  localparam logic [1:0] PAGE_NEXT = 2'd1;
  localparam logic [1:0] PAGE_PREV = 2'd2;

  // configuration register indexes
  localparam logic CFG_YEAR_MIN = 1'b0;
  localparam logic CFG_YEAR_MAX = 1'b1;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  typedef struct packed {
    date_t      date;
    logic [1:0] cursor;
  } sel_state_t;

  typedef struct packed {
    logic [YEAR_W-1:0] year_min;
    logic [YEAR_W-1:0] year_max;
  } year_range_t;

  // one result before the calendar info is attached
  typedef struct packed {
    date_t      date;
    logic [1:0] cursor;
    logic [1:0] page;
  } rec_t;

  // divisible by 4 and not by 100, or divisible by 400;
  // y/4 divisible by 25 is tested with the inverse of 25 modulo 1024
  function automatic logic leap_year(logic [YEAR_W-1:0] y);
    logic [19:0] prod;
    logic        div25;
    prod  = {10'd0, y[YEAR_W-1:2]} * 20'd41;
    div25 = (prod[9:0] <= 10'd40);
    return (y[1:0] == 2'd0) && (!div25 || (y[3:2] == 2'd0));
  endfunction

  function automatic logic [DAY_W-1:0] days_in(logic [YEAR_W-1:0] y,
                                               logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:    len = leap_year(y) ? 5'd29 : 5'd28;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

/* hdl/cds_step.sv */
// ----------------------------------------------------------------------------
// cds_step
// Next selected date, cursor and page step for one button event.
// ----------------------------------------------------------------------------
module cds_step import cds_pkg::*; (
  input  sel_state_t          cur,
  input  year_range_t         range,
  input  logic [1:0]          op,
  input  date_t               set_date,
  output sel_state_t          nxt,
  output logic [1:0]          page
);

  logic [YEAR_W:0]    y_up;
  logic               up_over;
  logic [YEAR_W-1:0]  y_up_c;
  logic [YEAR_W-1:0]  y_dec;
  logic               dn_under;
  logic [YEAR_W-1:0]  y_dn_c;
  logic [DAY_W-1:0]   md_cur;
  logic [DAY_W-1:0]   md_new;
  logic               d_up_over;
  logic               m_top;
  logic               m_bottom;
  logic               d_bottom;
  logic [YEAR_W-1:0]  ny;
  logic [MONTH_W-1:0] nm;
  logic [DAY_W-1:0]   nd;
  logic [DAY_W-1:0]   d_clamp;

  assign y_up     = {1'b0, cur.date.year} + 13'd1;
  assign up_over  = y_up > {1'b0, range.year_max};
  assign y_up_c   = up_over ? range.year_max : y_up[YEAR_W-1:0];
  assign y_dec    = cur.date.year - 12'd1;
  assign dn_under = (cur.date.year == 12'd0) || (y_dec < range.year_min);
  assign y_dn_c   = dn_under ? range.year_min : y_dec;

  assign md_cur    = days_in(cur.date.year, cur.date.month);
  assign d_up_over = ({1'b0, cur.date.day} + 6'd1) > {1'b0, md_cur};
  assign m_top     = cur.date.month >= MONTH_DEC;
  assign m_bottom  = cur.date.month <= MONTH_JAN;
  assign d_bottom  = cur.date.day <= 5'd1;

  // year and month first, the day depends on the new month length
  always_comb begin
    ny = cur.date.year;
    nm = cur.date.month;
    unique case (op)
      OP_RIGHT: begin
        if (cur.cursor == MODE_YEAR) begin
          ny = y_up_c;
        end else if (cur.cursor == MODE_MONTH ||
                     (cur.cursor == MODE_DAY && d_up_over)) begin
          if (m_top) begin
            ny = y_up_c;
            nm = up_over ? MONTH_DEC : MONTH_JAN;
          end else begin
            nm = cur.date.month + 4'd1;
          end
        end
      end
      OP_LEFT: begin
        if (cur.cursor == MODE_YEAR) begin
          ny = y_dn_c;
        end else if (cur.cursor == MODE_MONTH ||
                     (cur.cursor == MODE_DAY && d_bottom)) begin
          if (m_bottom) begin
            ny = y_dn_c;
            nm = MONTH_DEC;
          end else begin
            nm = cur.date.month - 4'd1;
          end
        end
      end
      OP_CENTER: begin
      end
      OP_SET: begin
        ny = set_date.year;
        nm = set_date.month;
      end
      default: begin
      end
    endcase
  end

  assign md_new  = days_in(ny, nm);
  assign d_clamp = (cur.date.day > md_new) ? md_new : cur.date.day;

  always_comb begin
    nd = cur.date.day;
    unique case (op)
      OP_RIGHT: begin
        if (cur.cursor == MODE_YEAR || cur.cursor == MODE_MONTH) begin
          nd = d_clamp;
        end else if (cur.cursor == MODE_DAY) begin
          if (d_up_over) begin
            // saturated at the top: last day of december
            nd = (m_top && up_over) ? md_new : 5'd1;
          end else begin
            nd = cur.date.day + 5'd1;
          end
        end
      end
      OP_LEFT: begin
        if (cur.cursor == MODE_YEAR || cur.cursor == MODE_MONTH) begin
          nd = d_clamp;
        end else if (cur.cursor == MODE_DAY) begin
          nd = d_bottom ? md_new : cur.date.day - 5'd1;
        end
      end
      OP_CENTER: begin
      end
      OP_SET: begin
        nd = set_date.day;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    nxt.date.year  = ny;
    nxt.date.month = nm;
    nxt.date.day   = nd;
    nxt.cursor     = (op == OP_CENTER) ? cur.cursor + 2'd1 : cur.cursor;
    page           = PAGE_NONE;
    if (cur.cursor == MODE_NAV && op == OP_RIGHT) begin
      page = PAGE_NEXT;
    end else if (cur.cursor == MODE_NAV && op == OP_LEFT) begin
      page = PAGE_PREV;
    end
  end

endmodule

/* hdl/cds_info.sv */
// ----------------------------------------------------------------------------
// cds_info
// Pipeline that attaches month length and weekday of the 1st to a result.
// ----------------------------------------------------------------------------
module cds_info import cds_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  rec_t             in_rec,
  output logic             out_valid,
  input  logic             out_ready,
  output rec_t             out_rec,
  output logic [DAY_W-1:0] out_len,
  output logic [2:0]       out_wd
);

  // floor(13 * (mm + 1) / 5) with march-based month numbering
  function automatic logic [5:0] zeller_term(logic [MONTH_W-1:0] m);
    logic [5:0] t;
    unique case (m)
      4'd1:    t = 6'd36;
      4'd2:    t = 6'd39;
      4'd3:    t = 6'd10;
      4'd4:    t = 6'd13;
      4'd5:    t = 6'd15;
      4'd6:    t = 6'd18;
      4'd7:    t = 6'd20;
      4'd8:    t = 6'd23;
      4'd9:    t = 6'd26;
      4'd10:   t = 6'd28;
      4'd11:   t = 6'd31;
      4'd12:   t = 6'd33;
      default: t = 6'd0;
    endcase
    return t;
  endfunction

  logic             v1, v2, v3;
  logic             en1, en2, en3, en4;
  rec_t             r1, r2, r3;
  logic [5:0]       q2;
  logic [DAY_W-1:0] len2, len3;
  logic [8:0]       s3;
  logic             mv3;

  logic [24:0]      prod_y;
  logic [12:0]      hund;
  logic [YEAR_W-1:0] rem_full;
  logic [6:0]       ry;
  logic             early;
  logic [6:0]       k;
  logic [5:0]       j;
  logic [8:0]       sum;
  logic             month_ok;
  logic [17:0]      prod_s;
  logic [5:0]       q7;
  logic [8:0]       r9;
  logic [2:0]       h;

  assign en4      = !out_valid || out_ready;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  // year / 100 by reciprocal, exact for 12-bit years
  assign prod_y = {13'd0, r1.date.year} * 25'd5243;

  // zeller sum on year + 400, one year less for january and february
  assign hund     = {7'd0, q2} * 13'd100;
  assign rem_full = r2.date.year - hund[YEAR_W-1:0];
  assign ry       = rem_full[6:0];
  assign early    = (r2.date.month == MONTH_JAN) || (r2.date.month == MONTH_FEB);
  assign month_ok = (r2.date.month >= MONTH_JAN) && (r2.date.month <= MONTH_DEC);

  always_comb begin
    if (early && ry == 7'd0) begin
      k = 7'd99;
      j = q2 + 6'd3;
    end else if (early) begin
      k = ry - 7'd1;
      j = q2 + 6'd4;
    end else begin
      k = ry;
      j = q2 + 6'd4;
    end
  end

  assign sum = 9'd1 + {3'd0, zeller_term(r2.date.month)} + {2'd0, k} + {4'd0, k[6:2]}
             + {5'd0, j[5:2]} + ({3'd0, j} * 9'd5);

  // sum mod 7 by reciprocal, sum stays below 512
  assign prod_s = {9'd0, s3} * 18'd293;
  assign q7     = prod_s[16:11];
  assign r9     = s3 - ({3'd0, q7} * 9'd7);
  assign h      = r9[2:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= in_valid;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        v3 <= v2;
      end
      if (en4) begin
        out_valid <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      r1 <= in_rec;
    end
    if (en2) begin
      r2   <= r1;
      q2   <= prod_y[24:19];
      len2 <= days_in(r1.date.year, r1.date.month);
    end
    if (en3) begin
      r3   <= r2;
      len3 <= len2;
      s3   <= sum;
      mv3  <= month_ok;
    end
    if (en4) begin
      out_rec <= r3;
      out_len <= len3;
      // zeller counts from saturday, shift to sunday first
      if (!mv3) begin
        out_wd <= 3'd0;
      end else begin
        out_wd <= (h == 3'd0) ? 3'd6 : h - 3'd1;
      end
    end
  end

  a_full_only_when_stalled: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("info pipeline blocked without an output stall");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_len >= 5'd28 && out_len <= 5'd31))
    else $error("month length out of range");

  a_wd_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_wd <= 3'd6))
    else $error("weekday out of range");

endmodule

/* hdl/calendar_date_stepper.sv */
// ----------------------------------------------------------------------------
// calendar_date_stepper
// Gregorian date selection stepped by button events.
// ----------------------------------------------------------------------------
// usage
//   s_* carries one button event per transaction: s_tuser holds the event
//   code (right, left, center, set date), s_tdata the date loaded by set date.
//   m_* returns one result per event: the date, cursor and page step after
//   the event, the month length and the weekday of the 1st of the month.
//   cfg_* writes the year range: index 0 year_min, index 1 year_max; writes
//   are always taken, and belong to idle periods.
// timing
//   the selected date and cursor are updated in the cycle an event is
//   accepted, so events may follow each other every cycle while s_tready
//   is high. the result passes an input register and three more stages
//   (year/100 multiply, zeller sum, mod-7 multiply into the output
//   register): one result per cycle sustained while m_tready is high.
// reset
//   date 2025-09-05, cursor navigate, year range 2020 to 2030, no results
//   pending. when m_tready stays low the pipeline fills, then s_tready drops
//   until the receiver takes a result; nothing is lost.
// ----------------------------------------------------------------------------
module calendar_date_stepper import cds_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // event stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // set_year[11:0], set_month[15:12], set_day[20:16]
  input  logic [1:0]  s_tuser,   // op[1:0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // cur_year[11:0], cur_month[15:12], cur_day[20:16],
                                 // field_cursor[22:21], page_step[24:23],
                                 // month_length[29:25], first_weekday[32:30]
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data
);

  sel_state_t  state;
  sel_state_t  state_next;
  year_range_t range;
  date_t       set_date;
  logic [1:0]  page;
  logic        accept;
  rec_t        in_rec;
  rec_t        out_rec;
  logic [DAY_W-1:0] out_len;
  logic [2:0]  out_wd;

  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;

  assign set_date.year  = s_tdata[11:0];
  assign set_date.month = s_tdata[15:12];
  assign set_date.day   = s_tdata[20:16];

  // event decode and date arithmetic
  cds_step u_step (
    .cur      (state),
    .range    (range),
    .op       (s_tuser),
    .set_date (set_date),
    .nxt      (state_next),
    .page     (page)
  );

  // selection state moves only when an event is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      state.date.year  <= 12'd2025;
      state.date.month <= 4'd9;
      state.date.day   <= 5'd5;
      state.cursor     <= MODE_NAV;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // year range registers
  always_ff @(posedge clk) begin
    if (rst) begin
      range.year_min <= 12'd2020;
      range.year_max <= 12'd2030;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_YEAR_MIN: range.year_min <= cfg_data;
        CFG_YEAR_MAX: range.year_max <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    in_rec.date   = state_next.date;
    in_rec.cursor = state_next.cursor;
    in_rec.page   = page;
  end

  // month length and weekday of the 1st, with output register
  cds_info u_info (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_rec    (in_rec),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_rec   (out_rec),
    .out_len   (out_len),
    .out_wd    (out_wd)
  );

  assign m_tdata = {7'd0, out_wd, out_len, out_rec.page, out_rec.cursor,
                    out_rec.date.day, out_rec.date.month, out_rec.date.year};

  a_center_keeps_date: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser == OP_CENTER) |=> (state.date == $past(state.date)))
    else $error("center event changed the date");

  a_center_moves_cursor: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser == OP_CENTER) |=> (state.cursor == $past(state.cursor) + 2'd1))
    else $error("center event did not advance the cursor");

  a_set_loads_date: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser == OP_SET) |=>
      (state.date == $past(set_date) && state.cursor == $past(state.cursor)))
    else $error("set date not loaded");

  a_idle_holds_state: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(state))
    else $error("selection changed without an event");

endmodule
